// File: rtl/srs_pkg.sv
// shared types, constants and fixed-point helpers for the ray step unit
package srs_pkg;

	localparam int FRAC_BITS = 24;
	localparam int Q_W = 32;
	localparam int R_W = 31;
	localparam int S_W = 25;
	localparam int P_W = 64;
	// divider: one setup stage, one stage per quotient bit, one result stage
	localparam int DIV_LAT = Q_W + 2;

	localparam logic signed [Q_W-1:0] S_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] S_MIN = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic [P_W-1:0] HALF_LSB = P_W'(1) << (FRAC_BITS - 1);

	// register indexes of the configuration port
	localparam logic CFG_HORIZON = 1'b0;
	localparam logic CFG_STEP = 1'b1;

	// ray values that ride alongside the arithmetic
	typedef struct packed {
		logic [R_W-1:0] r;
		logic signed [Q_W-1:0] phi;
		logic signed [Q_W-1:0] dr;
		logic signed [Q_W-1:0] dphi;
		logic signed [Q_W-1:0] t1;
		logic cap;
	} side_t;

	// one division request: signed numerator as magnitude and sign
	typedef struct packed {
		logic [Q_W-1:0] a_mag;
		logic a_neg;
		logic [R_W-1:0] b;
	} div_req_t;

	// magnitude back to a saturated signed word
	function automatic logic signed [Q_W-1:0] sat_mag(input logic neg, input logic [P_W-1:0] m);
		logic signed [Q_W-1:0] res;
		if (neg) begin
			if (m > P_W'(S_MAX) + P_W'(1)) res = S_MIN;
			else res = -Q_W'(m);
		end else begin
			if (m > P_W'(S_MAX)) res = S_MAX;
			else res = Q_W'(m);
		end
		return res;
	endfunction

	// rounded, saturated fixed-point product from a product of magnitudes
	function automatic logic signed [Q_W-1:0] mul_round(input logic neg, input logic [P_W-1:0] p);
		logic [P_W-1:0] m;
		m = (p + HALF_LSB) >> FRAC_BITS;
		return sat_mag(neg, m);
	endfunction

	function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] v);
		return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
	endfunction

	// saturate a grown sum to the signed word range
	function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W+1:0] v);
		logic signed [Q_W-1:0] res;
		if (v > (Q_W+2)'(S_MAX)) res = S_MAX;
		else if (v < (Q_W+2)'(S_MIN)) res = S_MIN;
		else res = Q_W'(v);
		return res;
	endfunction

endpackage

// File: rtl/schwarzschild_ray_step_unit.sv
// ray step unit: one semi-implicit Euler step per request through a 44-stage pipeline
// throughput: one request per cycle while the output is not stalled
// the two 34-stage pipelined dividers set the depth
// a stalled output holds the whole pipeline; bubbles are not squeezed out
// reset: asynchronous, clears all valid bits and loads horizon 0.2 and step 0.02
module schwarzschild_ray_step_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [srs_pkg::R_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [srs_pkg::R_W-1:0] radius_in,
	input logic signed [srs_pkg::Q_W-1:0] angle_in,
	input logic signed [srs_pkg::Q_W-1:0] radial_rate_in,
	input logic signed [srs_pkg::Q_W-1:0] angular_rate_in,
	output logic out_valid,
	input logic out_stall,
	output logic [srs_pkg::R_W-1:0] radius_out,
	output logic signed [srs_pkg::Q_W-1:0] angle_out,
	output logic signed [srs_pkg::Q_W-1:0] radial_rate_out,
	output logic signed [srs_pkg::Q_W-1:0] angular_rate_out,
	output logic captured
);

	logic [srs_pkg::R_W-1:0] horizon_q;
	logic [srs_pkg::S_W-1:0] step_q;
	logic en;
	logic v_s5;
	srs_pkg::side_t side_s5;
	srs_pkg::div_req_t req_a, req_b;
	logic signed [srs_pkg::Q_W-1:0] qa, qb;
	srs_pkg::side_t side_d [0:srs_pkg::DIV_LAT-1];
	logic vd [0:srs_pkg::DIV_LAT-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q <= srs_pkg::R_W'(3355443);
			step_q <= srs_pkg::S_W'(335544);
		end else if (cfg_we) begin
			case (cfg_index)
				srs_pkg::CFG_HORIZON: horizon_q <= cfg_data;
				srs_pkg::CFG_STEP: step_q <= cfg_data[srs_pkg::S_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a finished result is held
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	srs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.radius_in(radius_in),
		.angle_in(angle_in),
		.radial_rate_in(radial_rate_in),
		.angular_rate_in(angular_rate_in),
		.h(horizon_q),
		.v_s5(v_s5),
		.side_s5(side_s5),
		.req_a(req_a),
		.req_b(req_b)
	);

	srs_div_lane u_div_a (
		.clk(clk),
		.en(en),
		.req(req_a),
		.quo(qa)
	);

	srs_div_lane u_div_b (
		.clk(clk),
		.en(en),
		.req(req_b),
		.quo(qb)
	);

	// side values and valid bits delayed to match the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd[0] <= 1'b0;
		end else if (en) begin
			vd[0] <= v_s5;
		end
	end

	for (genvar k = 1; k < srs_pkg::DIV_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				side_d[k] <= side_d[k-1];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd[k] <= 1'b0;
			end else if (en) begin
				vd[k] <= vd[k-1];
			end
		end
	end

	srs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.v_in(vd[srs_pkg::DIV_LAT-1]),
		.side_in(side_d[srs_pkg::DIV_LAT-1]),
		.qa(qa),
		.qb(qb),
		.s(step_q),
		.out_valid(out_valid),
		.radius_out(radius_out),
		.angle_out(angle_out),
		.radial_rate_out(radial_rate_out),
		.angular_rate_out(angular_rate_out),
		.captured(captured)
	);

endmodule

// File: rtl/srs_div_lane.sv
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
module srs_div_lane (
	input logic clk,
	input logic en,
	input srs_pkg::div_req_t req,
	output logic signed [srs_pkg::Q_W-1:0] quo
);

	localparam int NST = srs_pkg::Q_W + 1;

	logic [srs_pkg::P_W-1:0] rem_s [0:NST-1];
	logic [srs_pkg::R_W-1:0] b_s [0:NST-1];
	logic [srs_pkg::Q_W-1:0] q_s [0:NST-1];
	logic neg_s [0:NST-1];
	logic ovf_s [0:NST-1];
	logic zero_s [0:NST-1];
	logic nz_s [0:NST-1];
	logic [srs_pkg::P_W-1:0] num;

	// scaled numerator plus half the divisor for rounding
	assign num = (srs_pkg::P_W'(req.a_mag) << srs_pkg::FRAC_BITS)
		+ srs_pkg::P_W'(req.b >> 1);

	// setup stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			b_s[0] <= req.b;
			q_s[0] <= '0;
			neg_s[0] <= req.a_neg;
			ovf_s[0] <= num >= (srs_pkg::P_W'(req.b) << srs_pkg::Q_W);
			zero_s[0] <= req.b == '0;
			nz_s[0] <= req.a_mag != '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < srs_pkg::Q_W; k++) begin : g_iter
		logic [srs_pkg::P_W-1:0] trial;
		logic take;
		assign trial = srs_pkg::P_W'(b_s[k]) << (srs_pkg::Q_W - 1 - k);
		assign take = rem_s[k] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
				q_s[k+1] <= q_s[k] | (take ? srs_pkg::Q_W'(1) << (srs_pkg::Q_W - 1 - k) : '0);
				b_s[k+1] <= b_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				zero_s[k+1] <= zero_s[k];
				nz_s[k+1] <= nz_s[k];
			end
		end
	end

	// overflow and a zero divisor saturate, 0/0 gives 0, else sign the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[NST-1]) begin
				quo <= !nz_s[NST-1] ? '0 : (neg_s[NST-1] ? srs_pkg::S_MIN : srs_pkg::S_MAX);
			end else if (ovf_s[NST-1]) begin
				quo <= neg_s[NST-1] ? srs_pkg::S_MIN : srs_pkg::S_MAX;
			end else begin
				quo <= srs_pkg::sat_mag(neg_s[NST-1], srs_pkg::P_W'(q_s[NST-1]));
			end
		end
	end

endmodule

// File: rtl/srs_front.sv
// front stages: horizon test, squared rates, products ahead of the dividers
module srs_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [srs_pkg::R_W-1:0] radius_in,
	input logic signed [srs_pkg::Q_W-1:0] angle_in,
	input logic signed [srs_pkg::Q_W-1:0] radial_rate_in,
	input logic signed [srs_pkg::Q_W-1:0] angular_rate_in,
	input logic [srs_pkg::R_W-1:0] h,
	output logic v_s5,
	output srs_pkg::side_t side_s5,
	output srs_pkg::div_req_t req_a,
	output srs_pkg::div_req_t req_b
);

	logic v_s1, v_s2, v_s3, v_s4;
	srs_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	logic [srs_pkg::R_W-1:0] d_s2, d_s3;
	logic [srs_pkg::P_W-1:0] p_dphi2_s2, p_dr2_s2, p_rd_s2, p_drdphi_s2;
	logic neg_s2;
	logic signed [srs_pkg::Q_W-1:0] dphi2_s3, dr2_s3, drdphi_s3, drdphi_s4, drdphi_s5;
	logic [srs_pkg::R_W-1:0] den_s3, den_s4, den_s5;
	logic [srs_pkg::P_W-1:0] q1_s4, q2_s4;
	logic signed [srs_pkg::Q_W-1:0] num2_s5;
	logic signed [srs_pkg::Q_W-1:0] rd;
	logic [srs_pkg::R_W-1:0] d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign d = side_s1.r - h;
	assign rd = srs_pkg::mul_round(1'b0, p_rd_s2);

	// stage 1 capture, stage 2 products of magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{r: radius_in, phi: angle_in, dr: radial_rate_in,
				dphi: angular_rate_in, t1: '0, cap: 1'b0};
			side_s2 <= '{r: side_s1.r, phi: side_s1.phi, dr: side_s1.dr,
				dphi: side_s1.dphi, t1: side_s1.t1, cap: side_s1.r <= h};
			d_s2 <= d;
			p_dphi2_s2 <= srs_pkg::P_W'(srs_pkg::mag32(side_s1.dphi))
				* srs_pkg::P_W'(srs_pkg::mag32(side_s1.dphi));
			p_dr2_s2 <= srs_pkg::P_W'(srs_pkg::mag32(side_s1.dr))
				* srs_pkg::P_W'(srs_pkg::mag32(side_s1.dr));
			p_rd_s2 <= srs_pkg::P_W'(side_s1.r) * srs_pkg::P_W'(d);
			p_drdphi_s2 <= srs_pkg::P_W'(srs_pkg::mag32(side_s1.dr))
				* srs_pkg::P_W'(srs_pkg::mag32(side_s1.dphi));
			neg_s2 <= side_s1.dr[srs_pkg::Q_W-1] != side_s1.dphi[srs_pkg::Q_W-1];
		end
	end

	// stage 3 rounding, doubled denominator
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			d_s3 <= d_s2;
			dphi2_s3 <= srs_pkg::mul_round(1'b0, p_dphi2_s2);
			dr2_s3 <= srs_pkg::mul_round(1'b0, p_dr2_s2);
			drdphi_s3 <= srs_pkg::mul_round(neg_s2, p_drdphi_s2);
			den_s3 <= rd[srs_pkg::R_W-1] ? {srs_pkg::R_W{1'b1}}
				: {rd[srs_pkg::R_W-2:0], 1'b0};
		end
	end

	// stage 4 second products
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			den_s4 <= den_s3;
			drdphi_s4 <= drdphi_s3;
			q1_s4 <= srs_pkg::P_W'(dphi2_s3[srs_pkg::R_W-1:0]) * srs_pkg::P_W'(d_s3);
			q2_s4 <= srs_pkg::P_W'(h) * srs_pkg::P_W'(dr2_s3[srs_pkg::R_W-1:0]);
		end
	end

	// stage 5 rounding, divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= '{r: side_s4.r, phi: side_s4.phi, dr: side_s4.dr,
				dphi: side_s4.dphi, t1: srs_pkg::mul_round(1'b0, q1_s4), cap: side_s4.cap};
			num2_s5 <= srs_pkg::mul_round(1'b0, q2_s4);
			den_s5 <= den_s4;
			drdphi_s5 <= drdphi_s4;
		end
	end

	assign req_a = '{a_mag: srs_pkg::Q_W'(num2_s5), a_neg: 1'b0, b: den_s5};
	assign req_b = '{a_mag: srs_pkg::mag32(drdphi_s5), a_neg: drdphi_s5[srs_pkg::Q_W-1],
		b: side_s5.r};

endmodule

// File: rtl/srs_back.sv
// back stages: accelerations, velocity update, position update, output register
module srs_back (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic v_in,
	input srs_pkg::side_t side_in,
	input logic signed [srs_pkg::Q_W-1:0] qa,
	input logic signed [srs_pkg::Q_W-1:0] qb,
	input logic [srs_pkg::S_W-1:0] s,
	output logic out_valid,
	output logic [srs_pkg::R_W-1:0] radius_out,
	output logic signed [srs_pkg::Q_W-1:0] angle_out,
	output logic signed [srs_pkg::Q_W-1:0] radial_rate_out,
	output logic signed [srs_pkg::Q_W-1:0] angular_rate_out,
	output logic captured
);

	logic v_b1, v_b2, v_b3, v_b4;
	srs_pkg::side_t side_b1, side_b2, side_b3, side_b4;
	logic signed [srs_pkg::Q_W-1:0] ar_b1, aphi_b1, ndr_b3, ndphi_b3, ndr_b4, ndphi_b4;
	logic [srs_pkg::P_W-1:0] par_b2, paphi_b2, pdr_b4, pdphi_b4;
	logic nar_b2, naphi_b2, ndrn_b4, ndphin_b4;
	logic signed [srs_pkg::Q_W+1:0] aphi_w, nr_w;
	logic signed [srs_pkg::Q_W-1:0] mr;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_b1 <= v_in;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			out_valid <= v_b4;
		end
	end

	assign aphi_w = -((srs_pkg::Q_W+2)'(qb) <<< 1);

	// accelerations
	always_ff @(posedge clk) begin
		if (en) begin
			side_b1 <= side_in;
			ar_b1 <= srs_pkg::sat_sum((srs_pkg::Q_W+2)'(side_in.t1) - (srs_pkg::Q_W+2)'(qa));
			aphi_b1 <= srs_pkg::sat_sum(aphi_w);
		end
	end

	// acceleration times step
	always_ff @(posedge clk) begin
		if (en) begin
			side_b2 <= side_b1;
			par_b2 <= srs_pkg::P_W'(srs_pkg::mag32(ar_b1)) * srs_pkg::P_W'(s);
			paphi_b2 <= srs_pkg::P_W'(srs_pkg::mag32(aphi_b1)) * srs_pkg::P_W'(s);
			nar_b2 <= ar_b1[srs_pkg::Q_W-1];
			naphi_b2 <= aphi_b1[srs_pkg::Q_W-1];
		end
	end

	// new rates
	always_ff @(posedge clk) begin
		if (en) begin
			side_b3 <= side_b2;
			ndr_b3 <= srs_pkg::sat_sum((srs_pkg::Q_W+2)'(side_b2.dr)
				+ (srs_pkg::Q_W+2)'(srs_pkg::mul_round(nar_b2, par_b2)));
			ndphi_b3 <= srs_pkg::sat_sum((srs_pkg::Q_W+2)'(side_b2.dphi)
				+ (srs_pkg::Q_W+2)'(srs_pkg::mul_round(naphi_b2, paphi_b2)));
		end
	end

	// new rates times step
	always_ff @(posedge clk) begin
		if (en) begin
			side_b4 <= side_b3;
			ndr_b4 <= ndr_b3;
			ndphi_b4 <= ndphi_b3;
			pdr_b4 <= srs_pkg::P_W'(srs_pkg::mag32(ndr_b3)) * srs_pkg::P_W'(s);
			pdphi_b4 <= srs_pkg::P_W'(srs_pkg::mag32(ndphi_b3)) * srs_pkg::P_W'(s);
			ndrn_b4 <= ndr_b3[srs_pkg::Q_W-1];
			ndphin_b4 <= ndphi_b3[srs_pkg::Q_W-1];
		end
	end

	assign mr = srs_pkg::mul_round(ndrn_b4, pdr_b4);
	assign nr_w = (srs_pkg::Q_W+2)'({1'b0, side_b4.r}) + (srs_pkg::Q_W+2)'(mr);

	// positions and the output register, captured rays pass unchanged
	always_ff @(posedge clk) begin
		if (en) begin
			captured <= side_b4.cap;
			if (side_b4.cap) begin
				radius_out <= side_b4.r;
				angle_out <= side_b4.phi;
				radial_rate_out <= side_b4.dr;
				angular_rate_out <= side_b4.dphi;
			end else begin
				if (nr_w < 0) radius_out <= '0;
				else if (nr_w > (srs_pkg::Q_W+2)'(srs_pkg::S_MAX)) radius_out <= '1;
				else radius_out <= nr_w[srs_pkg::R_W-1:0];
				angle_out <= srs_pkg::sat_sum((srs_pkg::Q_W+2)'(side_b4.phi)
					+ (srs_pkg::Q_W+2)'(srs_pkg::mul_round(ndphin_b4, pdphi_b4)));
				radial_rate_out <= ndr_b4;
				angular_rate_out <= ndphi_b4;
			end
		end
	end

endmodule

// File: rtl/srs_checker.sv
// port-level checks for the ray step unit and their binding
module srs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [srs_pkg::R_W-1:0] radius_out,
	input logic signed [srs_pkg::Q_W-1:0] angle_out
);

	// input side stalls only while a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without a held result");

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(radius_out) && $stable(angle_out))
		else $error("result payload changed while stalled");

	// with no result offered the input is never stalled
	a_no_new: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no result offered");

endmodule

bind schwarzschild_ray_step_unit srs_checker u_srs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.radius_out(radius_out),
	.angle_out(angle_out)
);
